[src/mce_pkg.sv]
package mce_pkg;

   // widths of the request and response fields
   localparam int CHAR_W   = 8;
   localparam int TONE_W   = 15;
   localparam int MS_W     = 16;

   // longest run in the code table
   localparam int CODE_MAX   = 7;
   localparam int CODE_LEN_W = 3;

   localparam int DEF_MAX_ELEMENTS = 7;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DOT_TONE_HZ      = 3'd0,
      CSR_DOT_DURATION_MS  = 3'd1,
      CSR_DASH_TONE_HZ     = 3'd2,
      CSR_DASH_DURATION_MS = 3'd3,
      CSR_DASH_PAUSE_MS    = 3'd4
   } csr_index_type;

   localparam logic [TONE_W-1:0] RST_DOT_TONE_HZ      = TONE_W'(400);
   localparam logic [MS_W-1:0]   RST_DOT_DURATION_MS  = MS_W'(100);
   localparam logic [TONE_W-1:0] RST_DASH_TONE_HZ     = TONE_W'(500);
   localparam logic [MS_W-1:0]   RST_DASH_DURATION_MS = MS_W'(200);
   localparam logic [MS_W-1:0]   RST_DASH_PAUSE_MS    = MS_W'(1);

   typedef struct packed {
      logic [TONE_W-1:0] dot_tone_hz;
      logic [MS_W-1:0]   dot_duration_ms;
      logic [TONE_W-1:0] dash_tone_hz;
      logic [MS_W-1:0]   dash_duration_ms;
      logic [MS_W-1:0]   dash_pause_ms;
   } cfg_type;

   // element pattern, first element in the msb, 1 is a dash
   typedef struct packed {
      logic [CODE_LEN_W-1:0] len;
      logic [CODE_MAX-1:0]   bits;
   } code_type;

   typedef struct packed {
      logic              is_dash;
      logic [TONE_W-1:0] tone_hz;
      logic [MS_W-1:0]   tone_ms;
      logic [MS_W-1:0]   pause_ms;
      logic              last_element;
   } elem_type;

endpackage

[src/mce_ifs.sv]
interface mce_req_if import mce_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface mce_rsp_if import mce_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              is_dash;
   logic [TONE_W-1:0] tone_hz;
   logic [MS_W-1:0]   tone_ms;
   logic [MS_W-1:0]   pause_ms;
   logic              last_element;

   modport source (output valid, output is_dash, output tone_hz, output tone_ms,
                   output pause_ms, output last_element, input ready);
   modport sink (input valid, input is_dash, input tone_hz, input tone_ms,
                 input pause_ms, input last_element, output ready);
endinterface

[src/mce_csr.sv]
module mce_csr import mce_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   csr_index_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            CSR_DOT_TONE_HZ:      cfg_in.dot_tone_hz      = pwdata[TONE_W-1:0];
            CSR_DOT_DURATION_MS:  cfg_in.dot_duration_ms  = pwdata[MS_W-1:0];
            CSR_DASH_TONE_HZ:     cfg_in.dash_tone_hz     = pwdata[TONE_W-1:0];
            CSR_DASH_DURATION_MS: cfg_in.dash_duration_ms = pwdata[MS_W-1:0];
            CSR_DASH_PAUSE_MS:    cfg_in.dash_pause_ms    = pwdata[MS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_DOT_TONE_HZ:      prdata = CSR_DATA_W'(cfg_ff.dot_tone_hz);
         CSR_DOT_DURATION_MS:  prdata = CSR_DATA_W'(cfg_ff.dot_duration_ms);
         CSR_DASH_TONE_HZ:     prdata = CSR_DATA_W'(cfg_ff.dash_tone_hz);
         CSR_DASH_DURATION_MS: prdata = CSR_DATA_W'(cfg_ff.dash_duration_ms);
         CSR_DASH_PAUSE_MS:    prdata = CSR_DATA_W'(cfg_ff.dash_pause_ms);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dot_tone_hz      <= RST_DOT_TONE_HZ;
         cfg_ff.dot_duration_ms  <= RST_DOT_DURATION_MS;
         cfg_ff.dash_tone_hz     <= RST_DASH_TONE_HZ;
         cfg_ff.dash_duration_ms <= RST_DASH_DURATION_MS;
         cfg_ff.dash_pause_ms    <= RST_DASH_PAUSE_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/mce_lookup.sv]
module mce_lookup import mce_pkg::*; (
   input  logic [CHAR_W-1:0] char_code,
   output code_type          code
);

   // code rom, patterns left-justified, 1 = dash
   function automatic code_type code_rom(input logic [CHAR_W-1:0] c);
      code_type r;
      r = '0;
      case (c)
         "A":   r = '{3'd2, 7'b0100000};
         "B":   r = '{3'd4, 7'b1000000};
         "C":   r = '{3'd4, 7'b1010000};
         "D":   r = '{3'd3, 7'b1000000};
         "E":   r = '{3'd1, 7'b0000000};
         "F":   r = '{3'd4, 7'b0010000};
         "G":   r = '{3'd3, 7'b1100000};
         "H":   r = '{3'd4, 7'b0000000};
         "I":   r = '{3'd2, 7'b0000000};
         "J":   r = '{3'd4, 7'b0111000};
         "K":   r = '{3'd3, 7'b1010000};
         "L":   r = '{3'd4, 7'b0100000};
         "M":   r = '{3'd2, 7'b1100000};
         "N":   r = '{3'd2, 7'b1000000};
         "O":   r = '{3'd3, 7'b1110000};
         "P":   r = '{3'd4, 7'b0110000};
         "Q":   r = '{3'd4, 7'b1101000};
         "R":   r = '{3'd3, 7'b0100000};
         "S":   r = '{3'd3, 7'b0000000};
         "T":   r = '{3'd1, 7'b1000000};
         "U":   r = '{3'd3, 7'b0010000};
         "V":   r = '{3'd4, 7'b0001000};
         "W":   r = '{3'd3, 7'b0110000};
         "X":   r = '{3'd4, 7'b1001000};
         "Y":   r = '{3'd4, 7'b1011000};
         "Z":   r = '{3'd4, 7'b1100000};
         "1":   r = '{3'd5, 7'b0111100};
         "2":   r = '{3'd5, 7'b0011100};
         "3":   r = '{3'd5, 7'b0001100};
         "4":   r = '{3'd5, 7'b0000100};
         "5":   r = '{3'd5, 7'b0000000};
         "6":   r = '{3'd5, 7'b1000000};
         "7":   r = '{3'd5, 7'b1100000};
         "8":   r = '{3'd5, 7'b1110000};
         "9":   r = '{3'd5, 7'b1111000};
         "0":   r = '{3'd5, 7'b1111100};
         ".":   r = '{3'd6, 7'b0101010};
         ",":   r = '{3'd6, 7'b1100110};
         "?":   r = '{3'd6, 7'b0011000};
         8'h27: r = '{3'd6, 7'b0111100};  // apostrophe
         "!":   r = '{3'd6, 7'b1010110};
         "/":   r = '{3'd5, 7'b1001000};
         "(":   r = '{3'd5, 7'b1011000};
         ")":   r = '{3'd6, 7'b1011010};
         "&":   r = '{3'd5, 7'b0100000};
         ":":   r = '{3'd6, 7'b1110000};
         ";":   r = '{3'd6, 7'b1010100};
         "=":   r = '{3'd5, 7'b1000100};
         "+":   r = '{3'd5, 7'b0101000};
         "-":   r = '{3'd6, 7'b1000010};
         "_":   r = '{3'd6, 7'b0011010};
         8'h22: r = '{3'd6, 7'b0100100};  // double quote
         "$":   r = '{3'd7, 7'b0001001};
         "@":   r = '{3'd6, 7'b0110100};
         default: r = '0;
      endcase
      return r;
   endfunction

   logic [CHAR_W-1:0] upper;

   always_comb begin
      if (char_code inside {["a":"z"]}) begin
         upper = char_code - CHAR_W'(32);
      end else begin
         upper = char_code;
      end
   end

   assign code = code_rom(upper);

endmodule

[src/mce_emit.sv]
module mce_emit import mce_pkg::*; #(
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  code_type in_code,
   input  cfg_type  cfg,
   output logic     out_valid,
   input  logic     out_ready,
   output elem_type out_elem
);

   localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);

   logic [CODE_MAX-1:0] pat_ff;
   logic [CODE_MAX-1:0] pat_in;
   logic [LEN_W-1:0]    left_ff;
   logic [LEN_W-1:0]    left_in;
   logic [LEN_W-1:0]    load_len;
   logic                out_valid_ff;
   logic                out_valid_in;
   elem_type            elem_ff;
   elem_type            elem_in;
   logic                busy;
   logic                advance;
   logic                last;
   logic                accept;
   logic                dash;

   always_comb begin
      if (int'(in_code.len) > MAX_ELEMENTS) begin
         load_len = LEN_W'(MAX_ELEMENTS);
      end else begin
         load_len = LEN_W'(in_code.len);
      end
   end

   assign busy     = (left_ff != '0);
   assign advance  = busy & (~out_valid_ff | out_ready);
   assign last     = (left_ff == LEN_W'(1));
   assign in_ready = ~busy | (advance & last);
   assign accept   = in_valid & in_ready;
   assign dash     = pat_ff[CODE_MAX-1];

   always_comb begin
      pat_in  = pat_ff;
      left_in = left_ff;
      if (accept) begin
         pat_in  = in_code.bits;
         left_in = load_len;
      end else if (advance) begin
         pat_in  = pat_ff << 1;
         left_in = left_ff - LEN_W'(1);
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_comb begin
      elem_in.is_dash      = dash;
      elem_in.tone_hz      = dash ? cfg.dash_tone_hz : cfg.dot_tone_hz;
      elem_in.tone_ms      = dash ? cfg.dash_duration_ms : cfg.dot_duration_ms;
      elem_in.pause_ms     = dash ? cfg.dash_pause_ms : '0;
      elem_in.last_element = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      if (advance) begin
         elem_ff <= elem_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_elem  = elem_ff;

endmodule

[src/morse_character_encoder.sv]
// channel   dir  handshake       payload
// req_ch    in   valid/ready     char_code
// rsp_ch    out  valid/ready     is_dash, tone_hz, tone_ms, pause_ms, last_element
// csr       in   apb write/read  five timing registers at byte address 4*index
//
// a request gives one response per morse element: the element
// shift register feeds the response register one element a cycle when not stalled
// characters without a code are taken and give no response
// the next request is taken in the cycle the last element moves out
// synchronous active-high reset restores the default tones and durations
// a stalled response holds its register; the shift register then waits
module morse_character_encoder import mce_pkg::*; #(
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
   input  logic                  clock,
   input  logic                  reset,
   mce_req_if.sink               req_ch,
   mce_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type  cfg;
   code_type code;
   elem_type elem;

   // register file for tones, durations and dash pause
   mce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // case folding and code rom, straight off the request payload
   mce_lookup u_lookup (
      .char_code (req_ch.char_code),
      .code      (code)
   );

   // element shift register plus response register
   mce_emit #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_code   (code),
      .cfg       (cfg),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_elem  (elem)
   );

   // unpack response fields
   assign rsp_ch.is_dash      = elem.is_dash;
   assign rsp_ch.tone_hz      = elem.tone_hz;
   assign rsp_ch.tone_ms      = elem.tone_ms;
   assign rsp_ch.pause_ms     = elem.pause_ms;
   assign rsp_ch.last_element = elem.last_element;

`ifndef SYNTHESIS
   // the rest of a run follows without a bubble
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_element) |=> rsp_ch.valid)
      else $error("element run broken before its last element");

   // dots never carry a pause
   a_dot_no_pause: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.is_dash) |-> (rsp_ch.pause_ms == '0))
      else $error("dot element with nonzero pause");

   // a stalled response stays valid and unchanged
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> (rsp_ch.valid && $stable(elem)))
      else $error("response changed while stalled");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top import mce_pkg::*; ();

   // pause after the last expected element: a character with no code may
   // still sit in the block, so give it the longest run
   localparam int SETTLE_CYCLES   = 2 * DEF_MAX_ELEMENTS + 4;
   // cycles with no accepted request, element or register write
   localparam int WATCHDOG_LIMIT  = 2000;
   // receiver hold-off used to fill the block and back up the request side
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int RANDOM_PER_PHASE = 16;
   localparam int PRESSURE_ITEMS   = 20;

   // register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(CSR_DASH_PAUSE_MS) + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = '1;

   // ------------------------------------------------------------------
   // expected element store and character encoder
   // ------------------------------------------------------------------
   class morse_scoreboard;
      cfg_type  timing;
      elem_type expected_elems[$];
      int       errors;

      function new();
         timing.dot_tone_hz      = RST_DOT_TONE_HZ;
         timing.dot_duration_ms  = RST_DOT_DURATION_MS;
         timing.dash_tone_hz     = RST_DASH_TONE_HZ;
         timing.dash_duration_ms = RST_DASH_DURATION_MS;
         timing.dash_pause_ms    = RST_DASH_PAUSE_MS;
         errors = 0;
      endfunction

      // register write as seen by the block, masked to the field width
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_DOT_TONE_HZ:      timing.dot_tone_hz      = value[TONE_W-1:0];
            CSR_DOT_DURATION_MS:  timing.dot_duration_ms  = value[MS_W-1:0];
            CSR_DASH_TONE_HZ:     timing.dash_tone_hz     = value[TONE_W-1:0];
            CSR_DASH_DURATION_MS: timing.dash_duration_ms = value[MS_W-1:0];
            CSR_DASH_PAUSE_MS:    timing.dash_pause_ms    = value[MS_W-1:0];
            default: ;
         endcase
      endfunction

      // itu element string, empty when the character has no code
      function string morse_of(logic [CHAR_W-1:0] ch);
         case (ch)
            "A": return ".-";     "B": return "-...";   "C": return "-.-.";
            "D": return "-..";    "E": return ".";      "F": return "..-.";
            "G": return "--.";    "H": return "....";   "I": return "..";
            "J": return ".---";   "K": return "-.-";    "L": return ".-..";
            "M": return "--";     "N": return "-.";     "O": return "---";
            "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
            "S": return "...";    "T": return "-";      "U": return "..-";
            "V": return "...-";   "W": return ".--";    "X": return "-..-";
            "Y": return "-.--";   "Z": return "--..";
            "1": return ".----";  "2": return "..---";  "3": return "...--";
            "4": return "....-";  "5": return ".....";  "6": return "-....";
            "7": return "--...";  "8": return "---..";  "9": return "----.";
            "0": return "-----";
            ".": return ".-.-.-"; ",": return "--..--"; "?": return "..--..";
            "'": return ".----."; "!": return "-.-.--"; "/": return "-..-.";
            "(": return "-.--.";  ")": return "-.--.-"; "&": return ".-...";
            ":": return "---..."; ";": return "-.-.-."; "=": return "-...-";
            "+": return ".-.-.";  "-": return "-....-"; "_": return "..--.-";
            "\"": return ".-..-."; "$": return "...-..-"; "@": return ".--.-.";
            default: return "";
         endcase
      endfunction

      // accepted request: queue one element per dot or dash
      function void encode_char(logic [CHAR_W-1:0] code);
         logic [CHAR_W-1:0] upper;
         string             pattern;
         int                count;
         elem_type          e;
         upper = code;
         if (code >= "a" && code <= "z") upper = code - ("a" - "A");
         pattern = morse_of(upper);
         count = pattern.len();
         if (count > DEF_MAX_ELEMENTS) count = DEF_MAX_ELEMENTS;
         for (int i = 0; i < count; i++) begin
            e.is_dash      = (pattern[i] == "-");
            e.tone_hz      = e.is_dash ? timing.dash_tone_hz : timing.dot_tone_hz;
            e.tone_ms      = e.is_dash ? timing.dash_duration_ms : timing.dot_duration_ms;
            e.pause_ms     = e.is_dash ? timing.dash_pause_ms : '0;
            e.last_element = (i == count - 1);
            expected_elems.push_back(e);
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_element(elem_type got);
         elem_type want;
         if (expected_elems.size() == 0) begin
            $display("%0t: element with none expected: dash %0b tone %0d ms %0d pause %0d last %0b",
                     $time, got.is_dash, got.tone_hz, got.tone_ms, got.pause_ms,
                     got.last_element);
            errors++;
            return;
         end
         want = expected_elems.pop_front();
         compare_field("is_dash", want.is_dash, got.is_dash);
         compare_field("tone_hz", want.tone_hz, got.tone_hz);
         compare_field("tone_ms", want.tone_ms, got.tone_ms);
         compare_field("pause_ms", want.pause_ms, got.pause_ms);
         compare_field("last_element", want.last_element, got.last_element);
      endfunction
   endclass

   // ------------------------------------------------------------------
   // clock, block and channels
   // ------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   mce_req_if req_if ();
   mce_rsp_if rsp_if ();

   morse_character_encoder u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   morse_scoreboard sb = new();

   // every character that has a code, both cases of the letters
   string coded_chars =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.,?'!/()&:;=+-_\"$@";

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_request   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   // offer one character, idling first at the current rate; valid stays
   // high after acceptance so requests can run back to back
   task automatic send_char(input logic [CHAR_W-1:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid     <= 1'b0;
         req_if.char_code <= CHAR_W'($urandom);
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.char_code <= code;
      do @(posedge clock); while (!req_if.ready);
      sb.encode_char(code);
   endtask

   // mostly coded characters, the rest any byte at all
   function automatic logic [CHAR_W-1:0] pick_char();
      if ($urandom_range(99) < 80)
         return coded_chars[$urandom_range(coded_chars.len() - 1)];
      return CHAR_W'($urandom_range(255));
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_char(pick_char());
      req_if.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------
   // setup then access; psel is left high so writes can run back to back
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(idx, value);
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] dot_hz, dot_ms,
                               input logic [CSR_DATA_W-1:0] dash_hz, dash_ms, pause_ms);
      csr_write(CSR_DOT_TONE_HZ, dot_hz);
      csr_write(CSR_DOT_DURATION_MS, dot_ms);
      csr_write(CSR_DASH_TONE_HZ, dash_hz);
      csr_write(CSR_DASH_DURATION_MS, dash_ms);
      csr_write(CSR_DASH_PAUSE_MS, pause_ms);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // all elements in, then let any uncoded character leave the block
   task automatic wait_drained();
      while (sb.expected_elems.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // element side: check on acceptance, then pick next ready
   // ------------------------------------------------------------------
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            sb.check_element({rsp_if.is_dash, rsp_if.tone_hz, rsp_if.tone_ms,
                              rsp_if.pause_ms, rsp_if.last_element});
         // long hold-off counted here so the sender keeps pushing meanwhile
         if (hold_request) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog: too long without any handshake means the block is stuck
   // ------------------------------------------------------------------
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (psel && penable && pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      logic [CHAR_W-1:0] directed_chars[$];

      // table edges, case folding bounds, longest and shortest runs,
      // punctuation, and bytes with no code at either end of the range
      directed_chars = '{
         8'h00, 8'hFF, 8'h80, 8'h7F, " ", 8'h60, "{", "@", "[", "a", "z", "A", "Z",
         "E", "T", "$", "0", "9", "\"", "'", ".", ")", "_", "m", "5"};

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.char_code = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset timing values, no idling
      foreach (directed_chars[i]) send_char(directed_chars[i]);
      req_if.valid <= 1'b0;
      wait_drained();

      // writes to unmapped indexes change nothing; then all ones, which
      // also shows the upper bits being dropped
      csr_write(CSR_SPARE_LO, '1);
      csr_write(CSR_SPARE_HI, '1);
      program_regs('1, '1, '1, '1, '1);
      send_random(RANDOM_PER_PHASE);
      wait_drained();

      // lowest legal values, sender mostly idle
      send_idle_pct = 68;
      program_regs(37, 1, 37, 1, 0);
      send_random(RANDOM_PER_PHASE);
      wait_drained();

      // silent tones and random durations, receiver mostly stalled
      send_idle_pct  = 0;
      recv_stall_pct = 68;
      program_regs(0, $urandom, 0, $urandom, $urandom);
      send_random(RANDOM_PER_PHASE);
      wait_drained();

      // fully random values, light idling on both sides
      send_idle_pct  = 20;
      recv_stall_pct = 20;
      program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
      send_random(RANDOM_PER_PHASE);
      wait_drained();

      // backpressure: receiver holds off while requests keep coming
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b1;
      send_random(PRESSURE_ITEMS);
      wait_drained();

      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[files.f]
src/mce_pkg.sv
src/mce_ifs.sv
src/mce_csr.sv
src/mce_lookup.sv
src/mce_emit.sv
src/morse_character_encoder.sv
dv/tb_top.sv
